/* rtl/cpfc_pkg.sv */
package cpfc_pkg;

    // frame buffer address width; the byte index port carries all of its bits
    localparam int INDEX_BITS = 21;

    localparam int DATA_W      = 8;
    localparam int BYTE_IDX_W  = 21;
    localparam int LINES_W     = 10;
    localparam int BYTES_W     = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LINES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES  = 2'd2;

    // configuration reset values
    localparam logic [LINES_W-1:0] FRAME_LINES_RST = 10'd144;
    localparam logic [BYTES_W-1:0] LINE_BYTES_RST  = 11'd352;

    typedef struct packed {
        logic               decimate_mode;
        logic [LINES_W-1:0] frame_lines;
        logic [BYTES_W-1:0] line_bytes;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]     pixel_byte;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic                  frame_last;
    } res_t;

endpackage

/* rtl/camera_parallel_frame_capture.sv */
// Frame capture from an 8-bit camera parallel port. Each input request is one
// sampled tick of vsync, href, pclk and the data pins; one request is taken
// every clock cycle while in_stall is low and advances the capture state by one
// step, and a byte taken on a pclk rising edge comes out through the output
// register with its frame index and a last-of-frame flag. Results pass through a
// two-slot output buffer, so input requests stall only when a result is held back
// with both slots full. Assert start_req while idle to arm one frame; configuration
// writes are taken every cycle and should be made only while the block is idle.
module camera_parallel_frame_capture (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sampled port ticks
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               start_req,
    input  logic                               vsync,
    input  logic                               href,
    input  logic                               pclk,
    input  logic [cpfc_pkg::DATA_W-1:0]        pixel_data,
    // captured bytes
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cpfc_pkg::DATA_W-1:0]        pixel_byte,
    output logic [cpfc_pkg::BYTE_IDX_W-1:0]    byte_index,
    output logic                               frame_last
);

    cpfc_pkg::cfg_t cfg;
    cpfc_pkg::res_t step_res;
    cpfc_pkg::res_t out_res;
    logic           step_en;
    logic           step_valid;
    logic           buf_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign step_en   = in_valid && !buf_full;

    cpfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpfc_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .cfg        (cfg),
        .start_req  (start_req),
        .vsync      (vsync),
        .href       (href),
        .pclk       (pclk),
        .pixel_data (pixel_data),
        .res_valid  (step_valid),
        .res        (step_res)
    );

    cpfc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_en && step_valid),
        .push_res  (step_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign pixel_byte = out_res.pixel_byte;
    assign byte_index = out_res.byte_index;
    assign frame_last = out_res.frame_last;

endmodule

/* rtl/cpfc_cfg.sv */
module cpfc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [cpfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output cpfc_pkg::cfg_t                   cfg
);

    cpfc_pkg::cfg_t cfg_reg;

    // register writes, one per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decimate_mode <= 1'b0;
            cfg_reg.frame_lines   <= cpfc_pkg::FRAME_LINES_RST;
            cfg_reg.line_bytes    <= cpfc_pkg::LINE_BYTES_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == cpfc_pkg::CFG_DECIMATE)
                cfg_reg.decimate_mode <= cfg_data[0];
            else if (cfg_index == cpfc_pkg::CFG_FRAME_LINES)
                cfg_reg.frame_lines <= cfg_data[cpfc_pkg::LINES_W-1:0];
            else if (cfg_index == cpfc_pkg::CFG_LINE_BYTES)
                cfg_reg.line_bytes <= cfg_data[cpfc_pkg::BYTES_W-1:0];
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/cpfc_step.sv */
module cpfc_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  cpfc_pkg::cfg_t                cfg,
    input  logic                          start_req,
    input  logic                          vsync,
    input  logic                          href,
    input  logic                          pclk,
    input  logic [cpfc_pkg::DATA_W-1:0]   pixel_data,
    output logic                          res_valid,
    output cpfc_pkg::res_t                res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_VS_HIGH,
        PH_VS_LOW,
        PH_HREF_HIGH,
        PH_SKIP_HIGH,
        PH_SKIP_LOW,
        PH_PCLK_HIGH,
        PH_PCLK_LOW,
        PH_HREF_LOW
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [cpfc_pkg::LINES_W-1:0]       line_count_reg, line_count_next;
    logic [cpfc_pkg::BYTES_W-1:0]       byte_count_reg, byte_count_next;
    logic [cpfc_pkg::INDEX_BITS-1:0]    write_index_reg, write_index_next;

    logic [cpfc_pkg::BYTES_W-1:0]       byte_count_inc;
    logic [cpfc_pkg::LINES_W:0]         lines_done;
    logic [cpfc_pkg::LINES_W-1:0]       line_count_inc;
    phase_t                             byte_phase;

    assign byte_count_inc = byte_count_reg + 1'b1;
    assign lines_done     = {1'b0, line_count_reg} + 1'b1;
    assign line_count_inc = line_count_reg + 1'b1;
    assign byte_phase     = cfg.decimate_mode ? PH_SKIP_HIGH : PH_PCLK_HIGH;

    // next state for one sampled tick
    always_comb
    begin
        phase_next       = phase_reg;
        line_count_next  = line_count_reg;
        byte_count_next  = byte_count_reg;
        write_index_next = write_index_reg;
        res_valid        = 1'b0;
        res.pixel_byte   = pixel_data;
        res.byte_index   = cpfc_pkg::BYTE_IDX_W'(write_index_reg);
        res.frame_last   = (byte_count_inc >= cfg.line_bytes) &&
                           (lines_done >= {1'b0, cfg.frame_lines});
        case (phase_reg)
            PH_VS_HIGH:
            begin
                if (vsync)
                    phase_next = PH_VS_LOW;
            end
            PH_VS_LOW:
            begin
                if (!vsync)
                begin
                    line_count_next  = '0;
                    byte_count_next  = '0;
                    write_index_next = '0;
                    phase_next = (cfg.frame_lines == '0) ? PH_IDLE : PH_HREF_HIGH;
                end
            end
            PH_HREF_HIGH:
            begin
                if (href)
                begin
                    byte_count_next = '0;
                    phase_next = (cfg.line_bytes == '0) ? PH_HREF_LOW : byte_phase;
                end
            end
            PH_SKIP_HIGH:
            begin
                if (pclk)
                    phase_next = PH_SKIP_LOW;
            end
            PH_SKIP_LOW:
            begin
                if (!pclk)
                    phase_next = PH_PCLK_HIGH;
            end
            PH_PCLK_HIGH:
            begin
                // byte taken on the pclk rising edge
                if (pclk)
                begin
                    byte_count_next  = byte_count_inc;
                    res_valid        = 1'b1;
                    write_index_next = write_index_reg + 1'b1;
                    phase_next       = PH_PCLK_LOW;
                end
            end
            PH_PCLK_LOW:
            begin
                if (!pclk)
                    phase_next = (byte_count_reg >= cfg.line_bytes) ? PH_HREF_LOW
                                                                    : byte_phase;
            end
            PH_HREF_LOW:
            begin
                if (!href)
                begin
                    line_count_next = line_count_inc;
                    phase_next = (line_count_inc >= cfg.frame_lines) ? PH_IDLE
                                                                     : PH_HREF_HIGH;
                end
            end
            default:
            begin
                phase_next = start_req ? PH_VS_HIGH : PH_IDLE;
            end
        endcase
    end

    // capture state, advanced once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            line_count_reg  <= '0;
            byte_count_reg  <= '0;
            write_index_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            line_count_reg  <= line_count_next;
            byte_count_reg  <= byte_count_next;
            write_index_reg <= write_index_next;
        end
    end

endmodule

/* rtl/cpfc_out_buf.sv */
module cpfc_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpfc_pkg::res_t  push_res,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output cpfc_pkg::res_t  out_res
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    cpfc_pkg::res_t out_reg, out_next;
    cpfc_pkg::res_t skid_reg, skid_next;
    logic           take;

    assign take = out_valid_reg && !out_stall;

    // output slot plus one skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = push_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

/* sim/tb_top.sv */
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 8;
    localparam int RANDOM_TICKS = 650;

    typedef enum logic [3:0] {
        CAP_IDLE,
        WAIT_VS_HIGH,
        WAIT_VS_LOW,
        WAIT_HREF_HIGH,
        SKIP_HIGH,
        SKIP_LOW,
        PCLK_HIGH,
        PCLK_LOW,
        WAIT_HREF_LOW
    } cap_phase_t;

    // expected capture behavior and the bytes still owed by the block
    class capture_scoreboard;
        logic                            decimate;
        logic [cpfc_pkg::LINES_W-1:0]    lines_cfg;
        logic [cpfc_pkg::BYTES_W-1:0]    bytes_cfg;
        cap_phase_t                      phase;
        logic [cpfc_pkg::LINES_W-1:0]    line_cnt;
        logic [cpfc_pkg::BYTES_W-1:0]    byte_cnt;
        logic [cpfc_pkg::INDEX_BITS-1:0] wr_index;
        cpfc_pkg::res_t                  bytes_due[$];
        int                              errors;

        function new();
            decimate  = 1'b0;
            lines_cfg = cpfc_pkg::FRAME_LINES_RST;
            bytes_cfg = cpfc_pkg::LINE_BYTES_RST;
            phase     = CAP_IDLE;
            line_cnt  = '0;
            byte_cnt  = '0;
            wr_index  = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [cpfc_pkg::CFG_IDX_W-1:0] idx,
                              logic [cpfc_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                cpfc_pkg::CFG_DECIMATE:    decimate  = d[0];
                cpfc_pkg::CFG_FRAME_LINES: lines_cfg = d[cpfc_pkg::LINES_W-1:0];
                cpfc_pkg::CFG_LINE_BYTES:  bytes_cfg = d[cpfc_pkg::BYTES_W-1:0];
                default: ;
            endcase
        endfunction

        function cap_phase_t byte_phase();
            return decimate ? SKIP_HIGH : PCLK_HIGH;
        endfunction

        // advance the capture by one sampled tick
        function void note_tick(bit st, bit vs, bit hr, bit pc,
                                logic [cpfc_pkg::DATA_W-1:0] d);
            cpfc_pkg::res_t exp_byte;
            case (phase)
                WAIT_VS_HIGH:
                    if (vs)
                        phase = WAIT_VS_LOW;
                WAIT_VS_LOW:
                    if (!vs)
                    begin
                        line_cnt = '0;
                        byte_cnt = '0;
                        wr_index = '0;
                        phase = (lines_cfg == 0) ? CAP_IDLE : WAIT_HREF_HIGH;
                    end
                WAIT_HREF_HIGH:
                    if (hr)
                    begin
                        byte_cnt = '0;
                        phase = (bytes_cfg == 0) ? WAIT_HREF_LOW : byte_phase();
                    end
                SKIP_HIGH:
                    if (pc)
                        phase = SKIP_LOW;
                SKIP_LOW:
                    if (!pc)
                        phase = PCLK_HIGH;
                PCLK_HIGH:
                    if (pc)
                    begin
                        byte_cnt = byte_cnt + 1'b1;
                        exp_byte.pixel_byte = d;
                        exp_byte.byte_index = cpfc_pkg::BYTE_IDX_W'(wr_index);
                        exp_byte.frame_last = (byte_cnt >= bytes_cfg) &&
                            ({1'b0, line_cnt} + 11'd1 >= {1'b0, lines_cfg});
                        bytes_due.push_back(exp_byte);
                        wr_index = wr_index + 1'b1;
                        phase = PCLK_LOW;
                    end
                PCLK_LOW:
                    if (!pc)
                        phase = (byte_cnt >= bytes_cfg) ? WAIT_HREF_LOW : byte_phase();
                WAIT_HREF_LOW:
                    if (!hr)
                    begin
                        line_cnt = line_cnt + 1'b1;
                        phase = (line_cnt >= lines_cfg) ? CAP_IDLE : WAIT_HREF_HIGH;
                    end
                default:
                begin
                    phase = CAP_IDLE;
                    if (st)
                        phase = WAIT_VS_HIGH;
                end
            endcase
        endfunction

        // compare one captured byte against the oldest expectation
        function void check_byte(cpfc_pkg::res_t got);
            cpfc_pkg::res_t exp_byte;
            if (bytes_due.size() == 0)
            begin
                $display("%0t: unexpected byte %02h index %0d last %0b", $time,
                         got.pixel_byte, got.byte_index, got.frame_last);
                errors++;
                return;
            end
            exp_byte = bytes_due.pop_front();
            if (got.pixel_byte !== exp_byte.pixel_byte)
            begin
                $display("%0t: pixel_byte expected %02h got %02h", $time,
                         exp_byte.pixel_byte, got.pixel_byte);
                errors++;
            end
            if (got.byte_index !== exp_byte.byte_index)
            begin
                $display("%0t: byte_index expected %0d got %0d", $time,
                         exp_byte.byte_index, got.byte_index);
                errors++;
            end
            if (got.frame_last !== exp_byte.frame_last)
            begin
                $display("%0t: frame_last expected %0b got %0b", $time,
                         exp_byte.frame_last, got.frame_last);
                errors++;
            end
        endfunction

        function int pending();
            return bytes_due.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [cpfc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [cpfc_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic                              start_req;
    logic                              vsync;
    logic                              href;
    logic                              pclk;
    logic [cpfc_pkg::DATA_W-1:0]       pixel_data;
    logic                              out_valid;
    logic                              out_stall;
    logic [cpfc_pkg::DATA_W-1:0]       pixel_byte;
    logic [cpfc_pkg::BYTE_IDX_W-1:0]   byte_index;
    logic                              frame_last;

    capture_scoreboard sb = new();
    int ticks_sent = 0;
    int steady_left = 0;
    int cycles = 0;

    camera_parallel_frame_capture u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_req  (start_req),
        .vsync      (vsync),
        .href       (href),
        .pclk       (pclk),
        .pixel_data (pixel_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_byte (pixel_byte),
        .byte_index (byte_index),
        .frame_last (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_byte('{pixel_byte: pixel_byte, byte_index: byte_index,
                            frame_last: frame_last});
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [cpfc_pkg::DATA_W-1:0] rbyte();
        return cpfc_pkg::DATA_W'($urandom_range(0, 255));
    endfunction

    // receiver back-pressure
    initial
    begin
        int g;
        int free;
        out_stall = 1'b0;
        forever
        begin
            free = ($urandom_range(0, 31) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
            repeat (free) @(negedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                out_stall <= 1'b1;
                repeat (g) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one sampled port tick as a request
    task automatic send_tick(input bit st, input bit vs, input bit hr, input bit pc,
                             input logic [cpfc_pkg::DATA_W-1:0] d);
        int gap;
        if (steady_left > 0)
        begin
            steady_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 63) == 0)
                steady_left = $urandom_range(20, 150);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        start_req  <= st;
        vsync      <= vs;
        href       <= hr;
        pclk       <= pc;
        pixel_data <= d;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_tick(st, vs, hr, pc, d);
        ticks_sent++;
    endtask

    task automatic write_cfg(input logic [cpfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpfc_pkg::CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // well-formed frame: arm, vsync pulse, then lines of pclk pulses
    task automatic send_frame(input int n_lines, input int n_pulses);
        send_tick(1'b1, 1'b0, 1'b0, rbit(), rbyte());
        repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'b0, 1'b0, rbit(), rbyte());
        repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b1, 1'b0, rbit(), rbyte());
        for (int l = 0; l < n_lines; l++)
        begin
            repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0, 1'b0, rbit(), rbyte());
            for (int p = 0; p < n_pulses; p++)
            begin
                repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0, 1'b1, 1'b0, rbyte());
                repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0, 1'b1, 1'b1, rbyte());
            end
            send_tick(1'b0, 1'b0, 1'b1, 1'b0, rbyte());
        end
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, rbyte());
    endtask

    // push a half-finished capture through to idle
    task automatic drain_capture();
        int guard;
        guard = 0;
        while (sb.phase != CAP_IDLE && guard < 100000)
        begin
            send_tick(1'b0, 1'b1, 1'b0, 1'b0, rbyte());
            send_tick(1'b0, 1'b0, 1'b1, 1'b0, rbyte());
            send_tick(1'b0, 1'b0, 1'b1, 1'b1, rbyte());
            send_tick(1'b0, 1'b0, 1'b1, 1'b0, rbyte());
            send_tick(1'b0, 1'b0, 1'b0, 1'b0, rbyte());
            guard++;
        end
    endtask

    // stop requests and wait until every owed byte is out
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // quiet the input side and let every owed byte come out
    task automatic settle();
        drain_capture();
        quiesce();
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // largest lengths, then shrunk while a line is being taken
    task automatic shrink_while_busy();
        settle();
        write_cfg(cpfc_pkg::CFG_DECIMATE, '0);
        write_cfg(cpfc_pkg::CFG_FRAME_LINES, cpfc_pkg::CFG_DATA_W'(1023));
        write_cfg(cpfc_pkg::CFG_LINE_BYTES, cpfc_pkg::CFG_DATA_W'(2047));
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, rbyte());
        send_tick(1'b0, 1'b1, 1'b0, 1'b0, rbyte());
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, rbyte());
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, rbyte());
        repeat (6)
        begin
            send_tick(1'b0, 1'b0, 1'b1, 1'b1, rbyte());
            send_tick(1'b0, 1'b0, 1'b1, 1'b0, rbyte());
        end
        quiesce();
        write_cfg(cpfc_pkg::CFG_LINE_BYTES, cpfc_pkg::CFG_DATA_W'(3));
        write_cfg(cpfc_pkg::CFG_FRAME_LINES, cpfc_pkg::CFG_DATA_W'(1));
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, rbyte());
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, rbyte());
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, rbyte());
    endtask

    task automatic run_setting(input bit dec, input int lines, input int nbytes,
                               input int frames, input bit noisy);
        logic [cpfc_pkg::CFG_DATA_W-1:0] d;
        int nl;
        int np;
        settle();
        d = cpfc_pkg::CFG_DATA_W'($urandom);
        d[0] = dec;
        write_cfg(cpfc_pkg::CFG_DECIMATE, d);
        d = cpfc_pkg::CFG_DATA_W'(lines);
        d[cpfc_pkg::CFG_DATA_W-1] = rbit();
        write_cfg(cpfc_pkg::CFG_FRAME_LINES, d);
        write_cfg(cpfc_pkg::CFG_LINE_BYTES, cpfc_pkg::CFG_DATA_W'(nbytes));
        repeat (frames)
        begin
            nl = (lines == 0) ? 2 : lines;
            np = nbytes * (dec ? 2 : 1);
            if (np == 0)
                np = 1;
            if (noisy)
            begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(5, 20))
                           send_tick(rbit(), rbit(), rbit(), rbit(), rbyte());
                    1: nl = nl + ($urandom_range(0, 1) ? 1 : -1);
                    2: np = np + ($urandom_range(0, 1) ? 1 : -1);
                    default: ;
                endcase
            end
            if (nl < 1)
                nl = 1;
            if (np < 1)
                np = 1;
            send_frame(nl, np);
        end
    endtask

    // stimulus
    initial
    begin
        int rand_base;
        int w;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = cpfc_pkg::CFG_DECIMATE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        start_req  = 1'b0;
        vsync      = 1'b0;
        href       = 1'b0;
        pclk       = 1'b0;
        pixel_data = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: one two-byte line, start while busy, data extremes
        write_cfg(cpfc_pkg::CFG_DECIMATE, 11'h7FE);
        write_cfg(cpfc_pkg::CFG_FRAME_LINES, 11'h401);
        write_cfg(cpfc_pkg::CFG_LINE_BYTES, 11'd2);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h5A);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'hA5);
        send_tick(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'h81);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'h7E);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'h11);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'h33);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'h44);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'hFF);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'h12);
        send_tick(1'b0, 1'b1, 1'b1, 1'b1, 8'h34);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h56);
        send_tick(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);

        // fixed settings: decimation, zero frame, zero line, longer frames
        run_setting(1'b1, 2, 3, 2, 1'b0);
        run_setting(1'b0, 0, 5, 2, 1'b0);
        run_setting(1'b1, 3, 0, 2, 1'b0);
        run_setting(1'b0, 12, 1, 1, 1'b0);
        run_setting(1'b1, 1, 40, 1, 1'b0);
        shrink_while_busy();

        // random small frames with some broken ones and junk
        rand_base = ticks_sent;
        while (ticks_sent - rand_base < RANDOM_TICKS)
            run_setting(rbit(),
                        ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5),
                        ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8),
                        $urandom_range(2, 5), 1'b1);

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        w = 0;
        while (sb.pending() != 0 && w < 200000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (16) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected bytes never came out", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* camera_parallel_frame_capture.f */
rtl/cpfc_pkg.sv
rtl/cpfc_cfg.sv
rtl/cpfc_step.sv
rtl/cpfc_out_buf.sv
rtl/camera_parallel_frame_capture.sv
sim/tb_top.sv
